### design/rns_pkg.sv
// ----------------------------------------------------------------------------
// rns_pkg: shared types and constants of the nearest sphere hit block
// Command kinds, queue item, sequencer states, fixed-point widths and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rns_pkg;

	// Field widths of the item payload.
	localparam int ID_W    = 6;
	localparam int POS_W   = 24;
	localparam int ANG_W   = 16;
	localparam int RANGE_W = 23;
	localparam int RSQ_W   = 24;

	// CORDIC datapath: Q16 values with headroom.
	localparam int TRIG_W = 20;
	localparam int ITERS  = 16;
	localparam int IT_W   = 4;
	localparam logic signed [TRIG_W-1:0] CORDIC_K    = 20'sd39797;
	localparam logic signed [TRIG_W-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [TRIG_W-1:0] PI_Q16      = 20'sd205887;

	// Input modes as they arrive on the bus.
	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_SHOOT  = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// Classified command kinds.
	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_UPDATE,
		CMD_SHOOT,
		CMD_REMOVE
	} cmd_kind_t;

	// One queued command from the front end to the back end.
	typedef struct packed {
		cmd_kind_t               kind;
		logic [ID_W-1:0]         player_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [ANG_W-1:0] pitch;
		logic signed [ANG_W-1:0] yaw;
		logic                    alive;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TRIG,
		ST_DIR,
		ST_SCAN,
		ST_EMIT
	} seq_state_t;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic signed [TRIG_W-1:0] atan_q16(input logic [IT_W-1:0] i);
		logic signed [TRIG_W-1:0] r;
		unique case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30386;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

endpackage

### design/rns_front.sv
// ----------------------------------------------------------------------------
// rns_front: input side of the nearest sphere hit block
// Accepts beats, classifies them into commands and holds them in a short
// queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module rns_front #(
	parameter int MAX_PLAYERS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,  // player_id, pos_x, pos_y, pos_z, pitch, yaw, alive, pad
	input  logic [1:0]    s_tuser,  // mode
	output logic          q_valid,
	input  logic          q_pop,
	output rns_pkg::cmd_t q_cmd
);

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	rns_pkg::cmd_t        queue_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]       count_q;
	rns_pkg::cmd_t        cmd_in;
	logic                 push, pop;

	// Classify the incoming beat.
	always_comb begin
		cmd_in.player_id = s_tdata[5:0];
		cmd_in.pos_x     = s_tdata[29:6];
		cmd_in.pos_y     = s_tdata[53:30];
		cmd_in.pos_z     = s_tdata[77:54];
		cmd_in.pitch     = s_tdata[93:78];
		cmd_in.yaw       = s_tdata[109:94];
		cmd_in.alive     = s_tdata[110];
		if (32'(s_tdata[5:0]) >= MAX_PLAYERS) begin
			cmd_in.kind = rns_pkg::CMD_NOP;
		end else if (s_tuser == rns_pkg::MODE_UPDATE) begin
			cmd_in.kind = rns_pkg::CMD_UPDATE;
		end else if (s_tuser == rns_pkg::MODE_SHOOT) begin
			cmd_in.kind = rns_pkg::CMD_SHOOT;
		end else if (s_tuser == rns_pkg::MODE_REMOVE) begin
			cmd_in.kind = rns_pkg::CMD_REMOVE;
		end else begin
			cmd_in.kind = rns_pkg::CMD_NOP;
		end
	end

	assign s_tready = (count_q != (PTR_W+1)'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/rns_cordic.sv
// ----------------------------------------------------------------------------
// rns_cordic: iterative sine and cosine
// Rotation-mode CORDIC, one iteration per cycle, sixteen iterations after a
// quadrant fold of angles beyond a quarter turn.
// ----------------------------------------------------------------------------
module rns_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rns_pkg::ANG_W-1:0]  angle,
	output logic                              done,
	output logic signed [rns_pkg::TRIG_W-1:0] sin_out,
	output logic signed [rns_pkg::TRIG_W-1:0] cos_out
);

	logic signed [rns_pkg::TRIG_W-1:0] x_q, y_q, z_q, z0;
	logic [rns_pkg::IT_W-1:0]          it_q;
	logic                              busy_q, neg_q, done_q;

	assign z0 = {angle[rns_pkg::ANG_W-1], angle, 3'b000};

	// Rotation datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= rns_pkg::CORDIC_K;
			y_q <= '0;
			if (z0 > rns_pkg::HALF_PI_Q16) begin
				z_q   <= z0 - rns_pkg::PI_Q16;
				neg_q <= 1'b1;
			end else if (z0 < -rns_pkg::HALF_PI_Q16) begin
				z_q   <= z0 + rns_pkg::PI_Q16;
				neg_q <= 1'b1;
			end else begin
				z_q   <= z0;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[rns_pkg::TRIG_W-1]) begin
				x_q <= x_q - (y_q >>> it_q);
				y_q <= y_q + (x_q >>> it_q);
				z_q <= z_q - rns_pkg::atan_q16(it_q);
			end else begin
				x_q <= x_q + (y_q >>> it_q);
				y_q <= y_q - (x_q >>> it_q);
				z_q <= z_q + rns_pkg::atan_q16(it_q);
			end
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == rns_pkg::IT_W'(rns_pkg::ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign sin_out = neg_q ? -y_q : y_q;
	assign cos_out = neg_q ? -x_q : x_q;

endmodule

### design/rns_back.sv
// ----------------------------------------------------------------------------
// rns_back: command execution of the nearest sphere hit block
// Owns the entity table, runs shots through the CORDIC and a pipelined
// projection over every entry but entry 0, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rns_back #(
	parameter int MAX_PLAYERS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_pop,
	input  rns_pkg::cmd_t                      q_cmd,
	input  logic [rns_pkg::RANGE_W-1:0]        range_limit,
	input  logic [rns_pkg::RSQ_W-1:0]          hit_radius_sq,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               out_hit,
	output logic [rns_pkg::ID_W-1:0]           out_victim_id,
	output logic [rns_pkg::RANGE_W-1:0]        out_hit_distance
);

	localparam int IDW = $clog2(MAX_PLAYERS);
	localparam int PW  = rns_pkg::POS_W;
	localparam int TW  = rns_pkg::TRIG_W;

	// Entity table.
	logic [3*PW-1:0]               pos_mem [MAX_PLAYERS];
	logic [2*rns_pkg::ANG_W-1:0]   aim_mem [MAX_PLAYERS];
	logic [MAX_PLAYERS-1:0]        valid_q, dead_q;
	logic [3*PW-1:0]               rd_pos_q;
	logic [2*rns_pkg::ANG_W-1:0]   rd_aim_q;
	logic                          rd_en;
	logic [IDW-1:0]                rd_addr, cmd_idx;

	rns_pkg::seq_state_t           state_q, state_d;
	logic                          can_emit, emit, emit_zero, cord_start;
	logic                          issue, scan_last, pipe_empty, shooter_live;

	logic [IDW-1:0]                shooter_q, k_q, best_id_q;
	logic                          issued_all_q, found_q;
	logic [rns_pkg::RANGE_W-1:0]   best_t_q;
	logic signed [PW-1:0]          sh_pos_q [3];
	logic signed [TW-1:0]          dir_q [3];

	logic signed [TW-1:0]          sp, cp, sy, cy;
	logic                          done_p, done_y;

	// Projection pipeline.
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                          live_s1, live_s2, ok_s3, ok_s4, ok_s5;
	logic [IDW-1:0]                k_s1, k_s2, k_s3, k_s4, k_s5;
	logic signed [PW:0]            d_s2 [3];
	logic signed [PW:0]            d_s3 [3];
	logic signed [PW:0]            d_s4 [3];
	logic signed [PW+TW:0]         p_s2 [3];
	logic signed [rns_pkg::RANGE_W:0] t_s3, t_s4;
	logic [rns_pkg::RANGE_W-1:0]   t_s5;
	logic signed [rns_pkg::RANGE_W+TW:0] m_s4 [3];
	logic [2*(PW+4)-1:0]           sq_s5 [3];
	logic signed [PW+TW+2:0]       dot;
	logic signed [PW+TW-14:0]      t_full;
	logic [2*(PW+4)+1:0]           dsq;

	logic signed [2*TW-1:0]        dx_prod, dz_prod;

	assign cmd_idx      = IDW'(q_cmd.player_id);
	assign can_emit     = !out_valid || out_ready;
	assign shooter_live = valid_q[cmd_idx] && !dead_q[cmd_idx];
	assign scan_last    = (k_q == IDW'(MAX_PLAYERS - 1));
	assign pipe_empty   = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);

	rns_cordic u_cordic_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.angle   (rd_aim_q[rns_pkg::ANG_W-1:0]),
		.done    (done_p),
		.sin_out (sp),
		.cos_out (cp)
	);

	rns_cordic u_cordic_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.angle   (rd_aim_q[2*rns_pkg::ANG_W-1:rns_pkg::ANG_W]),
		.done    (done_y),
		.sin_out (sy),
		.cos_out (cy)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_zero  = 1'b0;
		cord_start = 1'b0;
		issue      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cmd_idx;
		unique case (state_q)
			rns_pkg::ST_IDLE: begin
				if (q_valid && can_emit) begin
					q_pop = 1'b1;
					if (q_cmd.kind == rns_pkg::CMD_SHOOT && shooter_live) begin
						rd_en   = 1'b1;
						state_d = rns_pkg::ST_LOAD;
					end else begin
						emit      = 1'b1;
						emit_zero = 1'b1;
					end
				end
			end
			rns_pkg::ST_LOAD: begin
				cord_start = 1'b1;
				state_d    = rns_pkg::ST_TRIG;
			end
			rns_pkg::ST_TRIG: begin
				if (done_p) state_d = rns_pkg::ST_DIR;
			end
			rns_pkg::ST_DIR: begin
				state_d = rns_pkg::ST_SCAN;
			end
			rns_pkg::ST_SCAN: begin
				rd_addr = k_q;
				if (!issued_all_q) begin
					issue = 1'b1;
					rd_en = 1'b1;
				end else if (pipe_empty) begin
					state_d = rns_pkg::ST_EMIT;
				end
			end
			rns_pkg::ST_EMIT: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = rns_pkg::ST_IDLE;
				end
			end
			default: state_d = rns_pkg::ST_IDLE;
		endcase
	end

	// Table memories with registered read.
	always_ff @(posedge clk) begin
		if (state_q == rns_pkg::ST_IDLE && q_pop && q_cmd.kind == rns_pkg::CMD_UPDATE) begin
			pos_mem[cmd_idx] <= {q_cmd.pos_z, q_cmd.pos_y, q_cmd.pos_x};
			aim_mem[cmd_idx] <= {q_cmd.yaw, q_cmd.pitch};
		end
		if (rd_en) begin
			rd_pos_q <= pos_mem[rd_addr];
			rd_aim_q <= aim_mem[rd_addr];
		end
	end

	// Valid and dead marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dead_q  <= '0;
		end else begin
			if (state_q == rns_pkg::ST_IDLE && q_pop) begin
				if (q_cmd.kind == rns_pkg::CMD_UPDATE) begin
					valid_q[cmd_idx] <= 1'b1;
					dead_q[cmd_idx]  <= !q_cmd.alive;
				end else if (q_cmd.kind == rns_pkg::CMD_REMOVE) begin
					valid_q[cmd_idx] <= 1'b0;
				end
			end
			if (state_q == rns_pkg::ST_EMIT && emit && found_q) begin
				dead_q[best_id_q] <= 1'b1;
			end
		end
	end

	// Shooter capture and unit direction.
	assign dx_prod = sy * cp;
	assign dz_prod = cy * cp;

	always_ff @(posedge clk) begin
		if (state_q == rns_pkg::ST_IDLE && rd_en) begin
			shooter_q <= cmd_idx;
		end
		if (state_q == rns_pkg::ST_LOAD) begin
			sh_pos_q[0] <= rd_pos_q[PW-1:0];
			sh_pos_q[1] <= rd_pos_q[2*PW-1:PW];
			sh_pos_q[2] <= rd_pos_q[3*PW-1:2*PW];
		end
		if (state_q == rns_pkg::ST_DIR) begin
			dir_q[0] <= TW'(dx_prod >>> 16);
			dir_q[1] <= sp;
			dir_q[2] <= TW'(dz_prod >>> 16);
		end
	end

	// Scan counter and best-hit tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q          <= '0;
			issued_all_q <= 1'b0;
			found_q      <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (state_q == rns_pkg::ST_DIR) begin
				k_q          <= IDW'(1);
				issued_all_q <= 1'b0;
				found_q      <= 1'b0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
				if (scan_last) issued_all_q <= 1'b1;
			end
			if (v_s5 && ok_s5 && (dsq <= (2*(PW+4)+2)'(hit_radius_sq))
				&& (!found_q || t_s5 < best_t_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	// Stage 2: offset to target and its products with the direction.
	// Stage 3: ray distance and range check.
	// Stage 4: along-ray component per axis.
	// Stage 5: squared perpendicular terms.
	assign dot    = (PW+TW+3)'(p_s2[0]) + (PW+TW+3)'(p_s2[1]) + (PW+TW+3)'(p_s2[2]);
	assign t_full = (PW+TW-13)'(dot >>> 16);
	assign dsq    = (2*(PW+4)+2)'(sq_s5[0]) + (2*(PW+4)+2)'(sq_s5[1])
		+ (2*(PW+4)+2)'(sq_s5[2]);

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		live_s1 <= (k_q != shooter_q) && valid_q[k_q] && !dead_q[k_q];

		k_s2    <= k_s1;
		live_s2 <= live_s1;
		for (int j = 0; j < 3; j++) begin
			d_s2[j] <= (PW+1)'($signed(rd_pos_q[j*PW +: PW])) - (PW+1)'(sh_pos_q[j]);
			p_s2[j] <= ((PW+1)'($signed(rd_pos_q[j*PW +: PW])) - (PW+1)'(sh_pos_q[j]))
				* dir_q[j];
		end

		k_s3  <= k_s2;
		ok_s3 <= live_s2 && !t_full[PW+TW-14]
			&& (t_full <= (PW+TW-13)'($signed({1'b0, range_limit})));
		t_s3  <= (rns_pkg::RANGE_W+1)'(t_full);
		d_s3  <= d_s2;

		k_s4  <= k_s3;
		ok_s4 <= ok_s3;
		t_s4  <= t_s3;
		d_s4  <= d_s3;
		for (int j = 0; j < 3; j++) begin
			m_s4[j] <= t_s3 * dir_q[j];
		end

		k_s5  <= k_s4;
		ok_s5 <= ok_s4;
		t_s5  <= t_s4[rns_pkg::RANGE_W-1:0];
		for (int j = 0; j < 3; j++) begin
			sq_s5[j] <= (2*(PW+4))'(
				((PW+4)'(d_s4[j]) - (PW+4)'(m_s4[j] >>> 16))
				* ((PW+4)'(d_s4[j]) - (PW+4)'(m_s4[j] >>> 16)));
		end

		if (v_s5 && ok_s5 && (dsq <= (2*(PW+4)+2)'(hit_radius_sq))
			&& (!found_q || t_s5 < best_t_q)) begin
			best_t_q  <= t_s5;
			best_id_q <= k_s5;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (emit_zero || !found_q) begin
				out_hit          <= 1'b0;
				out_victim_id    <= '0;
				out_hit_distance <= '0;
			end else begin
				out_hit          <= 1'b1;
				out_victim_id    <= rns_pkg::ID_W'(best_id_q);
				out_hit_distance <= best_t_q;
			end
		end
	end

	// Both angle units run in lockstep.
	assert property (@(posedge clk) disable iff (!arst_n) done_p == done_y)
		else $error("pitch and yaw CORDIC out of step");

	// The projection pipeline is empty whenever the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rns_pkg::ST_IDLE |-> pipe_empty)
		else $error("projection pipeline busy while idle");

	// A result without a hit carries no victim.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(emit) && out_valid && !out_hit |-> out_victim_id == '0 && out_hit_distance == '0)
		else $error("miss reported with victim fields");

endmodule

### design/ray_nearest_sphere_hit.sv
// ----------------------------------------------------------------------------
// ray_nearest_sphere_hit: nearest target along a shooter's aim ray
// Update, remove and ignored items are answered from the idle state through the output
// register; a shot runs a table read, 16 CORDIC iterations and then one table entry per
// cycle through a 5-stage projection. Items are executed one at a time; a 4-deep input
// queue keeps accepting while a shot runs, until it is full. Reset clears all valid and
// dead marks at once.
// ----------------------------------------------------------------------------
module ray_nearest_sphere_hit #(
	parameter int MAX_PLAYERS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // player_id, pos_x, pos_y, pos_z, pitch, yaw, alive, pad
	input  logic [1:0]   s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // victim_id, hit_distance, pad
	output logic [0:0]   m_tuser,   // hit
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [23:0]  cfg_wdata
);

	localparam logic CFG_RANGE_LIMIT = 1'b0;
	localparam logic CFG_RADIUS_SQ   = 1'b1;

	logic [rns_pkg::RANGE_W-1:0] range_limit_q;
	logic [rns_pkg::RSQ_W-1:0]   hit_radius_sq_q;
	logic                        q_valid, q_pop, out_hit;
	rns_pkg::cmd_t               q_cmd;
	logic [rns_pkg::ID_W-1:0]    out_victim_id;
	logic [rns_pkg::RANGE_W-1:0] out_hit_distance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q   <= 23'd64000;
			hit_radius_sq_q <= 24'd94372;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_LIMIT: range_limit_q   <= cfg_wdata[rns_pkg::RANGE_W-1:0];
				CFG_RADIUS_SQ:   hit_radius_sq_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	rns_front #(.MAX_PLAYERS(MAX_PLAYERS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	rns_back #(.MAX_PLAYERS(MAX_PLAYERS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_cmd            (q_cmd),
		.range_limit      (range_limit_q),
		.hit_radius_sq    (hit_radius_sq_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_hit          (out_hit),
		.out_victim_id    (out_victim_id),
		.out_hit_distance (out_hit_distance)
	);

	// Result beat packing.
	assign m_tdata = {3'b000, out_hit_distance, out_victim_id};
	assign m_tuser = out_hit;

endmodule

### tb/tb_ray_nearest_sphere_hit.sv
// ----------------------------------------------------------------------------
// tb_ray_nearest_sphere_hit: self-checking bench for the nearest sphere hit
// A directed table covers reset behavior, the reserved id, ties, dead shooters, removed
// targets and field extremes. Random traffic follows in four phases of sender idling and
// receiver stalls under different range and radius settings. Every accepted beat is
// run through a local bit-exact predictor and each result beat is compared
// in order.
// ----------------------------------------------------------------------------
module tb_ray_nearest_sphere_hit;

	localparam int SLOTS = 64;
	localparam int RANDOM_BEATS = 1730;
	localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic CFG_RANGE = 1'b0;
	localparam logic CFG_RADIUS = 1'b1;

	typedef struct {
		logic [1:0]  mode;
		logic [5:0]  pid;
		logic signed [23:0] px, py, pz;
		logic signed [15:0] pitch, yaw;
		logic        alive;
	} order_t;

	typedef struct packed {
		logic        hit;
		logic [5:0]  vid;
		logic [22:0] hit_dist;
	} shot_res_t;

	typedef struct {
		order_t    ord;
		bit        known;
		shot_res_t fixed;
	} table_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [23:0]  cfg_wdata = '0;

	// Predictor state.
	logic [22:0] range_q;
	logic [23:0] radius_sq_q;
	bit          slot_valid [SLOTS];
	bit          slot_dead [SLOTS];
	longint      slot_pos [SLOTS][3];
	longint      slot_aim [SLOTS][2];

	shot_res_t   pending_hits [$];
	int          errors = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	table_row_t  rows [$];

	ray_nearest_sphere_hit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Rotation CORDIC with quadrant folding, Q16 sine and cosine.
	function automatic void trig(input longint ang, output longint s, output longint c);
		longint z, x, y, xs, ys;
		bit flip;
		z = ang * 8;
		x = rns_pkg::CORDIC_K;
		y = 0;
		flip = 0;
		if (z > rns_pkg::HALF_PI_Q16) begin
			z -= rns_pkg::PI_Q16;
			flip = 1;
		end else if (z < -rns_pkg::HALF_PI_Q16) begin
			z += rns_pkg::PI_Q16;
			flip = 1;
		end
		for (int i = 0; i < rns_pkg::ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_Q16[i];
			end else begin
				x += ys; y -= xs; z += ATAN_Q16[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// Applies one order to the predicted table and returns its result.
	function automatic shot_res_t apply_order(input order_t o);
		shot_res_t r;
		longint sp, cp, sy, cy, t, dsq, e, best_t;
		longint dir [3];
		longint d [3];
		int sh, best_id;
		bit found;
		r = '0;
		sh = int'(o.pid);
		found = 0;
		best_t = 0;
		best_id = 0;
		if (o.mode == rns_pkg::MODE_UPDATE) begin
			slot_pos[sh] = '{o.px, o.py, o.pz};
			slot_aim[sh] = '{o.pitch, o.yaw};
			slot_dead[sh] = !o.alive;
			slot_valid[sh] = 1;
		end else if (o.mode == rns_pkg::MODE_REMOVE) begin
			slot_valid[sh] = 0;
		end else if (o.mode == rns_pkg::MODE_SHOOT && slot_valid[sh] && !slot_dead[sh]) begin
			trig(slot_aim[sh][0], sp, cp);
			trig(slot_aim[sh][1], sy, cy);
			dir[0] = (sy * cp) >>> 16;
			dir[1] = sp;
			dir[2] = (cy * cp) >>> 16;
			// Entry 0 is reserved and never a target.
			for (int k = 1; k < SLOTS; k++) begin
				if (k == sh || !slot_valid[k] || slot_dead[k])
					continue;
				t = 0;
				for (int j = 0; j < 3; j++) begin
					d[j] = slot_pos[k][j] - slot_pos[sh][j];
					t += d[j] * dir[j];
				end
				t = t >>> 16;
				if (t < 0 || t > longint'(range_q))
					continue;
				dsq = 0;
				for (int j = 0; j < 3; j++) begin
					e = d[j] - ((t * dir[j]) >>> 16);
					dsq += e * e;
				end
				// Strict compare keeps the lowest id on equal distance.
				if (dsq <= longint'(radius_sq_q) && (!found || t < best_t)) begin
					found = 1;
					best_t = t;
					best_id = k;
				end
			end
			if (found) begin
				slot_dead[best_id] = 1;
				r.hit = 1;
				r.vid = 6'(best_id);
				r.hit_dist = best_t[22:0];
			end
		end
		return r;
	endfunction

	function automatic order_t mk(input logic [1:0] m, input int id, input int x, input int y,
		input int z, input int p, input int yw, input bit al);
		order_t o;
		o.mode = m;
		o.pid = 6'(id);
		o.px = 24'(x);
		o.py = 24'(y);
		o.pz = 24'(z);
		o.pitch = 16'(p);
		o.yaw = 16'(yw);
		o.alive = al;
		return o;
	endfunction

	// Appends one directed row; typed results in this table are all misses.
	function automatic void add_row(input order_t o, input bit known);
		table_row_t row;
		row.ord = o;
		row.known = known;
		row.fixed = '0;
		rows.insert(rows.size(), row);
	endfunction

	// Mostly a small cluster of ids placed near the z axis so that shots land.
	function automatic order_t rand_order();
		order_t o;
		int sel;
		sel = $urandom_range(0, 99);
		o.mode = sel < 50 ? rns_pkg::MODE_UPDATE : sel < 85 ? rns_pkg::MODE_SHOOT :
			sel < 95 ? rns_pkg::MODE_REMOVE : MODE_SPARE;
		o.pid = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 15))
			: 6'($urandom_range(0, 63));
		o.alive = $urandom_range(0, 99) < 90;
		if ($urandom_range(0, 99) < 75) begin
			o.px = 24'($signed($urandom_range(0, 512)) - 256);
			o.py = 24'($signed($urandom_range(0, 512)) - 256);
			o.pz = 24'($urandom_range(0, 8192));
			o.pitch = 16'($signed($urandom_range(0, 400)) - 200);
			o.yaw = 16'($signed($urandom_range(0, 400)) - 200);
		end else begin
			o.px = 24'($urandom);
			o.py = 24'($urandom);
			o.pz = 24'($urandom);
			o.pitch = 16'($urandom);
			o.yaw = 16'($urandom);
		end
		return o;
	endfunction

	// Offers one beat, idling first at the phase rate, and records its result.
	task automatic send_order(input order_t o, input bit known, input shot_res_t fixed);
		shot_res_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= o.mode;
		s_tdata <= {1'b0, o.alive, o.yaw, o.pitch, o.pz, o.py, o.px, o.pid};
		do @(posedge clk); while (!s_tready);
		r = apply_order(o);
		pending_hits.insert(pending_hits.size(), known ? fixed : r);
	endtask

	// Waits until every result is back and the block has drained.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_config(input logic [22:0] rng, input logic [23:0] rsq);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RANGE;
		cfg_wdata <= {1'b0, rng};
		@(posedge clk);
		cfg_index <= CFG_RADIUS;
		cfg_wdata <= rsq;
		@(posedge clk);
		cfg_we <= 1'b0;
		range_q = rng;
		radius_sq_q = rsq;
	endtask

	// Result side: check each accepted beat, then pick the next ready level.
	initial begin
		shot_res_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tdata[5:0], m_tdata[28:6]};
				if (pending_hits.size() == 0) begin
					$display("%0t unexpected result beat hit %0d victim %0d distance %0d",
						$time, got.hit, got.vid, got.hit_dist);
					errors++;
				end else begin
					want = pending_hits.pop_front();
					if (got.hit !== want.hit) begin
						$display("%0t hit: expected %0d actual %0d", $time, want.hit, got.hit);
						errors++;
					end
					if (got.vid !== want.vid) begin
						$display("%0t victim_id: expected %0d actual %0d",
							$time, want.vid, got.vid);
						errors++;
					end
					if (got.hit_dist !== want.hit_dist) begin
						$display("%0t hit_distance: expected %0d actual %0d",
							$time, want.hit_dist, got.hit_dist);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 99) >= stall_pct;
			end
		end
	end

	// Run limit.
	initial begin
		#(4 * 3000000);
		$display("tb: failure");
		$finish;
	end

	initial begin
		order_t o;
		int phase_idle [4];
		int phase_stall [4];
		phase_idle = '{0, 80, 0, 27};
		phase_stall = '{0, 0, 80, 27};
		range_q = 23'd64000;
		radius_sq_q = 24'd94372;
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 0;
			slot_dead[i] = 0;
		end

		// Directed table: rows with typed results are the no-hit cases.
		add_row(mk(rns_pkg::MODE_SHOOT, 5, 0, 0, 0, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 0, 0, 0, 768, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 1, 0, 0, 0, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 2, 0, 0, 2560, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 3, 0, 0, 2560, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_SHOOT, 1, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(rns_pkg::MODE_SHOOT, 1, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(rns_pkg::MODE_SHOOT, 1, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(rns_pkg::MODE_UPDATE, 63, 8388607, -8388608, 8388607, 32767, -32768, 1),
			1);
		add_row(mk(rns_pkg::MODE_UPDATE, 62, -8388608, 8388607, -8388608, -32768, 32767, 1),
			1);
		add_row(mk(rns_pkg::MODE_SHOOT, 63, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(rns_pkg::MODE_SHOOT, 62, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(rns_pkg::MODE_UPDATE, 4, 0, 0, -512, 0, 0, 0), 1);
		add_row(mk(rns_pkg::MODE_SHOOT, 4, 0, 0, 0, 0, 0, 0), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 2, 0, 0, 1280, 0, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_REMOVE, 2, 0, 0, 0, 0, 0, 0), 1);
		add_row(mk(rns_pkg::MODE_SHOOT, 1, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(MODE_SPARE, 7, -1, -1, -1, -1, -1, 1), 1);
		add_row(mk(rns_pkg::MODE_UPDATE, 5, 0, 0, 2048, 8192, 0, 1), 1);
		add_row(mk(rns_pkg::MODE_SHOOT, 0, 0, 0, 0, 0, 0, 0), 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_order(rows[i].ord, rows[i].known, rows[i].fixed);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					set_config(23'd64000, 24'd94372);
				end
				1: begin
					set_config(23'h7FFFFF, 24'hFFFFFF);
				end
				2: begin
					set_config(23'd0, 24'd0);
				end
				default: begin
					set_config(23'($urandom_range(1000, 200000)),
						24'($urandom_range(10000, 2000000)));
				end
			endcase
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int n = 0; n < RANDOM_BEATS / 4; n++) begin
				// Long receiver hold while the sender keeps offering beats.
				if (ph == 0 && n == 40)
					hold_left = 400;
				// No idling at all for a stretch in the mixed phase.
				if (ph == 3)
					idle_pct = (n % 150 < 40) ? 0 : phase_idle[ph];
				o = rand_order();
				send_order(o, 0, '0);
			end
		end
		drain();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
